FILE: src/isrkd_pkg.sv
// ----------------------------------------------------------------------------
// isrkd_pkg
// Shared types, constants and the key-to-mask lookup for the idle-synced
// serial receiver and key decoder.
// ----------------------------------------------------------------------------
package isrkd_pkg;

  localparam int unsigned TickWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned BitIdxWidth = 4;

  // configuration register indexes
  localparam logic [1:0] RegIdleTicks = 2'd0;
  localparam logic [1:0] RegFirstSampleTicks = 2'd1;
  localparam logic [1:0] RegBitTicks = 2'd2;

  localparam logic [TickWidth-1:0] IdleTicksReset = 16'd1275;
  localparam logic [TickWidth-1:0] FirstSampleTicksReset = 16'd135;
  localparam logic [TickWidth-1:0] BitTicksReset = 16'd100;

  localparam logic [ByteWidth-1:0] MaskReleased = 8'hFF;

  typedef struct packed {
    logic [TickWidth-1:0] idle_ticks;
    logic [TickWidth-1:0] first_sample_ticks;
    logic [TickWidth-1:0] bit_ticks;
  } cfg_t;

  typedef struct packed {
    logic [ByteWidth-1:0] drive_mask;
    logic                 byte_valid;
    logic [ByteWidth-1:0] received_byte;
  } result_t;

  // key code to pin drive mask, 0 bits pull a pin low
  function automatic logic [ByteWidth-1:0] key_mask(input logic [ByteWidth-1:0] key);
    logic [ByteWidth-1:0] m;
    case (key)
      8'd1:    m = 8'hF3;
      8'd2:    m = 8'hBF;
      8'd3:    m = 8'h7F;
      8'd5:    m = 8'hEF;
      8'd6:    m = 8'hDF;
      default: m = MaskReleased;
    endcase
    return m;
  endfunction

endpackage

FILE: src/isrkd_core.sv
// ----------------------------------------------------------------------------
// isrkd_core
// Receiver state machine: idle-gap hunt, start-bit wait, timed data sampling
// and key decoding. Advances one step per accepted line sample.
// ----------------------------------------------------------------------------
module isrkd_core #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                line_level,
  input  isrkd_pkg::cfg_t     cfg,
  output isrkd_pkg::result_t res
);

  typedef enum logic [1:0] {
    PH_HUNT  = 2'd0,
    PH_START = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  phase_t                                 phase;
  phase_t                                 phase_next;
  logic [isrkd_pkg::TickWidth-1:0]        tick_count;
  logic [isrkd_pkg::TickWidth-1:0]        tick_count_next;
  logic [isrkd_pkg::BitIdxWidth-1:0]      bit_index;
  logic [isrkd_pkg::BitIdxWidth-1:0]      bit_index_next;
  logic [isrkd_pkg::ByteWidth-1:0]        shift_byte;
  logic [isrkd_pkg::ByteWidth-1:0]        shift_byte_next;
  logic [isrkd_pkg::ByteWidth-1:0]        mask_hold;
  logic [isrkd_pkg::ByteWidth-1:0]        mask_hold_next;
  logic [isrkd_pkg::ByteWidth-1:0]        last_byte;
  logic [isrkd_pkg::ByteWidth-1:0]        last_byte_next;
  logic                                   valid_next;

  logic [isrkd_pkg::TickWidth-1:0]        tick_inc;
  logic [isrkd_pkg::TickWidth-1:0]        target;
  logic [isrkd_pkg::BitIdxWidth-1:0]      bit_inc;
  logic [isrkd_pkg::ByteWidth-1:0]        shift_sampled;

  assign tick_inc = tick_count + isrkd_pkg::TickWidth'(1);
  assign target   = (bit_index == '0) ? cfg.first_sample_ticks : cfg.bit_ticks;
  assign bit_inc  = bit_index + isrkd_pkg::BitIdxWidth'(1);

  // data bit lands at its lsb-first position
  always_comb begin
    shift_sampled = shift_byte;
    if (line_level) begin
      shift_sampled[bit_index[2:0]] = 1'b1;
    end
  end

  // next-state logic for one line sample
  always_comb begin
    phase_next      = phase;
    tick_count_next = tick_count;
    bit_index_next  = bit_index;
    shift_byte_next = shift_byte;
    mask_hold_next  = mask_hold;
    last_byte_next  = last_byte;
    valid_next      = 1'b0;
    unique case (phase)
      PH_START: begin
        if (!line_level) begin
          phase_next      = PH_DATA;
          tick_count_next = '0;
          bit_index_next  = '0;
          shift_byte_next = '0;
        end
      end
      PH_DATA: begin
        tick_count_next = tick_inc;
        if (tick_inc >= target) begin
          tick_count_next = '0;
          shift_byte_next = shift_sampled;
          bit_index_next  = bit_inc;
          if (bit_inc >= isrkd_pkg::BitIdxWidth'(DATA_BITS)) begin
            valid_next     = 1'b1;
            last_byte_next = shift_sampled;
            mask_hold_next = isrkd_pkg::key_mask(shift_sampled);
            phase_next     = PH_HUNT;
            bit_index_next = '0;
          end
        end
      end
      default: begin
        // hunting for an idle gap; unused code behaves the same
        phase_next = PH_HUNT;
        if (line_level) begin
          tick_count_next = tick_inc;
          if (tick_inc >= cfg.idle_ticks) begin
            phase_next      = PH_START;
            tick_count_next = '0;
          end
        end else begin
          tick_count_next = '0;
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      tick_count <= '0;
      bit_index  <= '0;
      shift_byte <= '0;
      mask_hold  <= isrkd_pkg::MaskReleased;
      last_byte  <= '0;
    end else if (step) begin
      phase      <= phase_next;
      tick_count <= tick_count_next;
      bit_index  <= bit_index_next;
      shift_byte <= shift_byte_next;
      mask_hold  <= mask_hold_next;
      last_byte  <= last_byte_next;
    end
  end

  // result for the sample being taken
  assign res.drive_mask    = mask_hold_next;
  assign res.byte_valid    = valid_next;
  assign res.received_byte = last_byte_next;

`ifndef SYNTH
  // bit index never rests at or past the byte length
  a_bit_index_range: assert property (@(posedge clk) disable iff (rst)
    bit_index < isrkd_pkg::BitIdxWidth'(DATA_BITS))
    else $error("bit index out of range");

  // outside data phase the bit index is parked at zero
  a_bit_index_parked: assert property (@(posedge clk) disable iff (rst)
    (phase != PH_DATA) |-> (bit_index == '0))
    else $error("bit index not cleared outside data phase");

  // a completed byte only comes out of the data phase
  a_valid_from_data: assert property (@(posedge clk) disable iff (rst)
    valid_next |-> (phase == PH_DATA))
    else $error("byte flagged outside data phase");

  // a completed byte updates the held byte and returns to hunting
  a_valid_updates: assert property (@(posedge clk) disable iff (rst)
    (step && valid_next) |=> (phase == PH_HUNT && last_byte == $past(shift_sampled)))
    else $error("completed byte not stored");
`endif

endmodule

FILE: src/idle_synced_serial_rx_key_decoder_unit.sv
// A result appears in the output register in the cycle after its sample is accepted.
// Throughput: one line sample per cycle; the output register frees as it is read,
// so a sample is accepted whenever the register is empty or being read.
// Reset: phase hunts for an idle gap, counters and byte clear, mask reads 0xFF,
// configuration registers return to 1275 / 135 / 100 ticks.
// ----------------------------------------------------------------------------
// idle_synced_serial_rx_key_decoder_unit
// Top level: configuration registers, sample handshake and result register
// around the receiver core.
// ----------------------------------------------------------------------------
module idle_synced_serial_rx_key_decoder_unit #(
  parameter int unsigned DATA_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [1:0]                          cfg_index,
  input  logic [isrkd_pkg::TickWidth-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                line_level,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [isrkd_pkg::ByteWidth-1:0]     drive_mask,
  output logic                                byte_valid,
  output logic [isrkd_pkg::ByteWidth-1:0]     received_byte
);

  isrkd_pkg::cfg_t    cfg;
  isrkd_pkg::result_t res;
  isrkd_pkg::result_t out_item;
  logic               step;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.idle_ticks         <= isrkd_pkg::IdleTicksReset;
      cfg.first_sample_ticks <= isrkd_pkg::FirstSampleTicksReset;
      cfg.bit_ticks          <= isrkd_pkg::BitTicksReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        isrkd_pkg::RegIdleTicks:        cfg.idle_ticks         <= cfg_data;
        isrkd_pkg::RegFirstSampleTicks: cfg.first_sample_ticks <= cfg_data;
        isrkd_pkg::RegBitTicks:         cfg.bit_ticks          <= cfg_data;
        default: ;
      endcase
    end
  end

  // take a sample when the result register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  isrkd_core #(
    .DATA_BITS(DATA_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .line_level (line_level),
    .cfg        (cfg),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_item <= res;
    end
  end

  assign drive_mask    = out_item.drive_mask;
  assign byte_valid    = out_item.byte_valid;
  assign received_byte = out_item.received_byte;

`ifndef SYNTH
  // an accepted sample always yields a pending result next cycle
  a_step_fills: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted item produced no result");

  // a stalled result blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("sample accepted over a stalled result");

  // a stalled result keeps its payload
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");
`endif

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the idle-synced serial receiver and key decoder.
// Serial frames built from the live register settings, broken frames and line
// noise are driven through the sample handshake under random stalls on both
// sides. A built-in line decoder predicts mask, byte flag and byte for every
// sample, and each result is checked against it.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DataBits = 8;
  localparam logic [1:0] SpareIndex = 2'd3;
  localparam int RandomItems = 1500;
  localparam int HoldCycles = 200;
  localparam int CycleLimit = 600000;

  typedef enum logic [1:0] {RxHunt, RxStart, RxData} rx_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [isrkd_pkg::TickWidth-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic line_level = 1'b1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [isrkd_pkg::ByteWidth-1:0] drive_mask;
  logic byte_valid;
  logic [isrkd_pkg::ByteWidth-1:0] received_byte;

  // decoder copy: registers and receive state
  isrkd_pkg::cfg_t rx_cfg;
  rx_phase_t rx_phase;
  logic [isrkd_pkg::TickWidth-1:0] rx_ticks;
  logic [isrkd_pkg::BitIdxWidth-1:0] rx_bit;
  logic [isrkd_pkg::ByteWidth-1:0] rx_shift;
  logic [isrkd_pkg::ByteWidth-1:0] rx_mask;
  logic [isrkd_pkg::ByteWidth-1:0] rx_last;

  logic line_samples_due[$];
  isrkd_pkg::result_t key_results_due[$];

  int lines_pushed = 0;
  int lines_taken = 0;
  int mismatch_count = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int send_wait = 0;
  int recv_wait = 0;
  int hold_requests = 0;
  int holds_begun = 0;
  int hold_left = 0;
  bit send_steady = 1'b0;
  bit recv_steady = 1'b0;
  logic line_taken = 1'b0;
  logic result_taken = 1'b0;

  idle_synced_serial_rx_key_decoder_unit #(
    .DATA_BITS(DataBits)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .line_level(line_level),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive_mask(drive_mask),
    .byte_valid(byte_valid),
    .received_byte(received_byte)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // pins pulled low per key code, everything else released
  function automatic logic [isrkd_pkg::ByteWidth-1:0] key_to_mask(
      input logic [isrkd_pkg::ByteWidth-1:0] key);
    logic [isrkd_pkg::ByteWidth-1:0] pulled;
    pulled = '0;
    case (key)
      8'd1: pulled = 8'b0000_1100;
      8'd2: pulled[6] = 1'b1;
      8'd3: pulled[7] = 1'b1;
      8'd5: pulled[4] = 1'b1;
      8'd6: pulled[5] = 1'b1;
      default: pulled = '0;
    endcase
    return ~pulled;
  endfunction

  // advance the decoder copy by one line sample
  function automatic isrkd_pkg::result_t decode_line_sample(input logic line);
    isrkd_pkg::result_t r;
    logic [isrkd_pkg::TickWidth-1:0] target;
    r = '0;
    case (rx_phase)
      RxStart: begin
        if (!line) begin
          rx_phase = RxData;
          rx_ticks = '0;
          rx_bit = '0;
          rx_shift = '0;
        end
      end
      RxData: begin
        target = (rx_bit == 0) ? rx_cfg.first_sample_ticks : rx_cfg.bit_ticks;
        rx_ticks = rx_ticks + 16'd1;
        if (rx_ticks >= target) begin
          rx_ticks = '0;
          if (line) rx_shift[rx_bit[2:0]] = 1'b1;
          rx_bit = rx_bit + 4'd1;
          if (rx_bit >= DataBits) begin
            r.byte_valid = 1'b1;
            rx_last = rx_shift;
            rx_mask = key_to_mask(rx_shift);
            rx_phase = RxHunt;
            rx_bit = '0;
          end
        end
      end
      default: begin
        rx_phase = RxHunt;
        if (line) begin
          rx_ticks = rx_ticks + 16'd1;
          if (rx_ticks >= rx_cfg.idle_ticks) begin
            rx_phase = RxStart;
            rx_ticks = '0;
          end
        end else begin
          rx_ticks = '0;
        end
      end
    endcase
    r.drive_mask = rx_mask;
    r.received_byte = rx_last;
    return r;
  endfunction

  function automatic int draw_gap(input bit steady);
    if (steady || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 11);
  endfunction

  // a zero tick count acts as one
  function automatic int eff_ticks(input logic [isrkd_pkg::TickWidth-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic logic [isrkd_pkg::TickWidth-1:0] pick_ticks(input int hi);
    if ($urandom_range(0, 11) == 0) return '0;
    return isrkd_pkg::TickWidth'($urandom_range(1, hi));
  endfunction

  function automatic logic [isrkd_pkg::ByteWidth-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      case ($urandom_range(0, 4))
        0: return 8'd1;
        1: return 8'd2;
        2: return 8'd3;
        3: return 8'd5;
        default: return 8'd6;
      endcase
    end
    if (sel == 5) begin
      case ($urandom_range(0, 3))
        0: return 8'd0;
        1: return 8'd4;
        2: return 8'd7;
        default: return 8'hFF;
      endcase
    end
    return isrkd_pkg::ByteWidth'($urandom_range(0, 255));
  endfunction

  task automatic note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at result %0d: %s", results_seen, msg);
  endtask

  task automatic queue_line(input logic v);
    line_samples_due.push_back(v);
    lines_pushed++;
  endtask

  task automatic queue_run(input logic v, input int n);
    repeat (n) queue_line(v);
  endtask

  // idle gap, start bit and data samples at the current settings;
  // cut stops the frame after cut - 1 data-phase samples
  task automatic queue_frame(input logic [isrkd_pkg::ByteWidth-1:0] key, input bit noisy,
                             input int cut);
    int f;
    int bt;
    int b;
    int s;
    f = eff_ticks(rx_cfg.first_sample_ticks);
    bt = eff_ticks(rx_cfg.bit_ticks);
    queue_run(1'b1, eff_ticks(rx_cfg.idle_ticks) + $urandom_range(0, 3));
    queue_line(1'b0);
    b = 0;
    for (s = 1; s <= f + 7 * bt && s != cut; s++) begin
      if (s > f + b * bt) b++;
      if (noisy && s != f + b * bt && $urandom_range(0, 3) == 0)
        queue_line(1'($urandom_range(0, 1)));
      else
        queue_line(key[b]);
    end
  endtask

  // long high run that ends any reception and finds the idle gap again
  task automatic queue_resync();
    queue_run(1'b1, eff_ticks(rx_cfg.first_sample_ticks) + 7 * eff_ticks(rx_cfg.bit_ticks)
              + eff_ticks(rx_cfg.idle_ticks) + 2);
  endtask

  // wait until every sample is taken and every result checked
  task automatic drain();
    while (lines_taken != lines_pushed || key_results_due.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx,
                           input logic [isrkd_pkg::TickWidth-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      isrkd_pkg::RegIdleTicks: rx_cfg.idle_ticks = val;
      isrkd_pkg::RegFirstSampleTicks: rx_cfg.first_sample_ticks = val;
      isrkd_pkg::RegBitTicks: rx_cfg.bit_ticks = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // sample handshake: take the item, predict its result
  always @(posedge clk) begin
    line_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      lines_taken <= lines_taken + 1;
      key_results_due.push_back(decode_line_sample(line_level));
    end
  end

  // sample driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !line_taken) begin
      // hold the item until taken
    end else if (send_wait != 0) begin
      in_valid <= 1'b0;
      send_wait <= send_wait - 1;
    end else if (line_samples_due.size() != 0) begin
      in_valid <= 1'b1;
      line_level <= line_samples_due.pop_front();
      send_wait <= draw_gap(send_steady);
      if ($urandom_range(0, 31) == 0) send_steady <= !send_steady;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // result receiver with per-item stalls and requested long hold-offs
  always @(negedge clk) begin : result_sink
    int gap;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (holds_begun != hold_requests) begin
      out_ready <= 1'b0;
      holds_begun <= holds_begun + 1;
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (result_taken) begin
      gap = draw_gap(recv_steady);
      if ($urandom_range(0, 31) == 0) recv_steady <= !recv_steady;
      if (gap == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        recv_wait <= gap - 1;
      end
    end else if (recv_wait != 0) begin
      out_ready <= 1'b0;
      recv_wait <= recv_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result check against the oldest prediction
  always @(posedge clk) begin : result_check
    isrkd_pkg::result_t want;
    result_taken <= !rst && out_valid && out_ready;
    if (!rst && out_valid && out_ready) begin
      results_seen <= results_seen + 1;
      if (key_results_due.size() == 0) begin
        note_failure($sformatf("unexpected result mask %0h flag %0b byte %0h",
                               drive_mask, byte_valid, received_byte));
      end else begin
        want = key_results_due.pop_front();
        if (drive_mask !== want.drive_mask)
          note_failure($sformatf("drive_mask expected %0h got %0h", want.drive_mask, drive_mask));
        if (byte_valid !== want.byte_valid)
          note_failure($sformatf("byte_valid expected %0b got %0b", want.byte_valid, byte_valid));
        if (received_byte !== want.received_byte)
          note_failure($sformatf("received_byte expected %0h got %0h",
                                 want.received_byte, received_byte));
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("idle_synced_serial_rx_key_decoder_unit regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    int random_base;
    int phase_no;
    int frames;
    int n;
    int pick;
    bit slow;
    rx_cfg.idle_ticks = isrkd_pkg::IdleTicksReset;
    rx_cfg.first_sample_ticks = isrkd_pkg::FirstSampleTicksReset;
    rx_cfg.bit_ticks = isrkd_pkg::BitTicksReset;
    rx_phase = RxHunt;
    rx_ticks = '0;
    rx_bit = '0;
    rx_shift = '0;
    rx_mask = isrkd_pkg::MaskReleased;
    rx_last = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // hunting at reset settings, low samples restart the count
    queue_line(1'b0);
    queue_line(1'b1);
    queue_line(1'b1);
    queue_line(1'b0);
    drain();

    // zero registers act as one, spare index ignored
    write_reg(isrkd_pkg::RegIdleTicks, '0);
    write_reg(isrkd_pkg::RegFirstSampleTicks, '0);
    write_reg(isrkd_pkg::RegBitTicks, '0);
    write_reg(SpareIndex, 16'h0003);
    queue_frame(8'd1, 1'b0, 0);
    drain();

    // largest idle gap, then lowered mid-count
    write_reg(isrkd_pkg::RegIdleTicks, 16'hFFFF);
    write_reg(isrkd_pkg::RegFirstSampleTicks, 16'hFFFF);
    queue_run(1'b1, 3);
    drain();
    write_reg(isrkd_pkg::RegIdleTicks, 16'd2);
    write_reg(isrkd_pkg::RegFirstSampleTicks, 16'd1);
    queue_line(1'b1);
    queue_line(1'b0);
    queue_line(1'b1);
    queue_line(1'b1);
    queue_line(1'b0);
    drain();

    // bit spacing raised to the top during reception, then lowered
    write_reg(isrkd_pkg::RegBitTicks, 16'hFFFF);
    queue_line(1'b1);
    queue_line(1'b0);
    queue_line(1'b1);
    drain();
    write_reg(isrkd_pkg::RegBitTicks, 16'd1);
    queue_run(1'b0, 5);
    queue_resync();
    drain();

    // random settings, mostly clean frames with some broken ones and noise
    random_base = lines_pushed;
    phase_no = 0;
    while (lines_pushed - random_base < RandomItems) begin
      drain();
      slow = ($urandom_range(0, 5) == 0);
      write_reg(isrkd_pkg::RegIdleTicks, pick_ticks(slow ? 40 : 10));
      write_reg(isrkd_pkg::RegFirstSampleTicks, pick_ticks(slow ? 40 : 8));
      write_reg(isrkd_pkg::RegBitTicks, pick_ticks(slow ? 35 : 5));
      if ($urandom_range(0, 3) == 0) write_reg(SpareIndex, isrkd_pkg::TickWidth'($urandom));
      frames = slow ? 2 : $urandom_range(3, 8);
      for (n = 0; n < frames; n++) begin
        pick = $urandom_range(0, 9);
        if (pick < 8) begin
          queue_frame(pick_key(), pick == 7, 0);
        end else if (pick == 8) begin
          queue_frame(pick_key(), 1'b0, $urandom_range(1, 8));
          queue_resync();
        end else begin
          repeat ($urandom_range(5, 30)) queue_line(1'($urandom_range(0, 1)));
          queue_resync();
        end
      end
      // long receiver hold-off while samples keep coming
      if (phase_no == 1 || phase_no == 6) hold_requests++;
      phase_no++;
    end
    drain();
    repeat (4) @(posedge clk);

    if (mismatch_count == 0)
      $display("idle_synced_serial_rx_key_decoder_unit regression: pass");
    else
      $display("idle_synced_serial_rx_key_decoder_unit regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/isrkd_pkg.sv
src/isrkd_core.sv
src/idle_synced_serial_rx_key_decoder_unit.sv
verif/tb_top.sv
